>>> sv/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DefDepth         = 16;
  localparam int unsigned DefPriorityWidth = 16;
  localparam int unsigned DataWidth        = 32;
  localparam int unsigned PrioFieldWidth   = 16;

  typedef enum logic [0:0] {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } spq_func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DEQ_EMPTY = 2'd1,
    ST_ENQ_FULL  = 2'd2
  } spq_status_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

>>> sv/stable_priority_queue_core.sv
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_tvalid / in_tready   | tuser: func; tdata: data_in, priority_in
// out_    | output    | out_tvalid / out_tready | tuser: status; tdata: result fields
//
// Every accepted item updates the whole chain of cells together, so one item is taken per
// cycle unless out_tready stalls; the result is in the output register on the next cycle.
// A new item is taken while the output register is empty or being emptied.
// If out_tready stays low while a result is held, in_tready falls and the queue contents hold.
// Reset clears the entry count and the output valid flag only.
module stable_priority_queue_core #(
  parameter int unsigned DEPTH          = spq_pkg::DefDepth,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DefPriorityWidth,
  localparam int unsigned CountWidth    = $clog2(DEPTH + 1),
  localparam int unsigned OutBits       = 97 + CountWidth,
  localparam int unsigned OutTdataWidth = ((OutBits + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [0:0]               in_tuser,   // [0] func
  input  logic [47:0]              in_tdata,   // [31:0] data_in, [47:32] priority_in
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [1:0]               out_tuser,  // [1:0] status
  // [31:0] removed_data, [47:32] removed_priority, [79:48] front_data,
  // [95:80] front_priority, [96] is_empty, then entry_count, zero padding above
  output logic [OutTdataWidth-1:0] out_tdata
);
  import spq_pkg::*;

  localparam int unsigned IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CountWidth-1:0]             count_r;
  logic [CountWidth-1:0]             count_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [1:0]                        status_r;
  logic [1:0]                        status_nxt;
  logic [DataWidth-1:0]              rem_data_r;
  logic [DataWidth-1:0]              rem_data_nxt;
  logic [PrioFieldWidth-1:0]         rem_prio_r;
  logic [PrioFieldWidth-1:0]         rem_prio_nxt;
  logic [DataWidth-1:0]              front_data_r;
  logic [DataWidth-1:0]              front_data_nxt;
  logic [PrioFieldWidth-1:0]         front_prio_r;
  logic [PrioFieldWidth-1:0]         front_prio_nxt;

  logic                              accept;
  logic                              is_enq;
  logic                              full;
  logic                              empty;
  spq_ctl_t                          ctl;
  logic [DataWidth-1:0]              new_data;
  logic signed [PRIORITY_WIDTH-1:0]  new_prio;
  logic [PRIORITY_WIDTH-1:0]         front_prio_full;
  logic [PRIORITY_WIDTH-1:0]         rem_prio_full;

  logic [DataWidth-1:0]              cell_data [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0]  cell_prio [DEPTH];
  logic [DEPTH-1:0]                  cell_gt;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign is_enq   = (in_tuser[0] == FUNC_ENQ);
  assign full     = (count_r == CountWidth'(DEPTH));
  assign empty    = (count_r == '0);
  assign ctl.enq  = accept && is_enq && !full;
  assign ctl.deq  = accept && !is_enq && !empty;
  assign new_data = in_tdata[31:0];

  // The priority field is zero-extended or narrowed to the stored width, whose top bit is the sign.
  always_comb begin
    for (int b = 0; b < PRIORITY_WIDTH; b++) begin
      new_prio[b] = (b < PrioFieldWidth) ? in_tdata[32 + b] : 1'b0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                              left_gt;
    logic [DataWidth-1:0]              left_data;
    logic signed [PRIORITY_WIDTH-1:0]  left_prio;
    logic [DataWidth-1:0]              right_data;
    logic signed [PRIORITY_WIDTH-1:0]  right_prio;

    if (i == 0) begin : g_head
      assign left_gt   = 1'b0;
      assign left_data = new_data;
      assign left_prio = new_prio;
    end else begin : g_body
      assign left_gt   = cell_gt[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (count_r > CountWidth'(i)),
      .new_data  (new_data),
      .new_prio  (new_prio),
      .left_gt   (left_gt),
      .left_data (left_data),
      .left_prio (left_prio),
      .right_data(right_data),
      .right_prio(right_prio),
      .data      (cell_data[i]),
      .prio      (cell_prio[i]),
      .gt        (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    status_nxt      = status_r;
    rem_data_nxt    = rem_data_r;
    front_data_nxt  = front_data_r;
    front_prio_full = cell_prio[0];
    rem_prio_full   = cell_prio[0];

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      out_valid_nxt  = 1'b1;
      status_nxt     = ST_OK;
      rem_data_nxt   = '0;
      front_data_nxt = cell_data[0];
      priority if (is_enq && full) begin
        status_nxt = ST_ENQ_FULL;
      end else if (is_enq) begin
        count_nxt = count_r + 1'b1;
        if (cell_gt[0]) begin
          front_data_nxt  = new_data;
          front_prio_full = new_prio;
        end
      end else if (empty) begin
        status_nxt = ST_DEQ_EMPTY;
      end else begin
        count_nxt      = count_r - 1'b1;
        rem_data_nxt   = cell_data[0];
        front_data_nxt = cell_data[IdxWidth'(1)];
        front_prio_full = cell_prio[IdxWidth'(1)];
      end
      if (count_nxt == '0) begin
        front_data_nxt  = '1;
        front_prio_full = '0;
      end
    end
  end

  // Stored priorities are narrowed or sign-extended to the 16-bit result fields.
  always_comb begin
    front_prio_nxt = front_prio_r;
    rem_prio_nxt   = rem_prio_r;
    if (accept) begin
      for (int b = 0; b < PrioFieldWidth; b++) begin
        front_prio_nxt[b] = (b < PRIORITY_WIDTH) ? front_prio_full[b]
                                                 : front_prio_full[PRIORITY_WIDTH-1];
        rem_prio_nxt[b]   = (b < PRIORITY_WIDTH) ? rem_prio_full[b]
                                                 : rem_prio_full[PRIORITY_WIDTH-1];
      end
      if (!ctl.deq) begin
        rem_prio_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    rem_data_r   <= rem_data_nxt;
    rem_prio_r   <= rem_prio_nxt;
    front_data_r <= front_data_nxt;
    front_prio_r <= front_prio_nxt;
  end

  // Count and empty flag are read from the live count, which only moves on acceptance.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OutTdataWidth'({count_r, (count_r == '0), front_prio_r,
                                      front_data_r, rem_prio_r, rem_data_r});

endmodule

>>> sv/spq_cell.sv
module spq_cell #(
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DefPriorityWidth
) (
  input  logic                                  clk,
  input  spq_pkg::spq_ctl_t                     ctl,
  input  logic                                  occupied,
  input  logic [spq_pkg::DataWidth-1:0]         new_data,
  input  logic signed [PRIORITY_WIDTH-1:0]      new_prio,
  input  logic                                  left_gt,
  input  logic [spq_pkg::DataWidth-1:0]         left_data,
  input  logic signed [PRIORITY_WIDTH-1:0]      left_prio,
  input  logic [spq_pkg::DataWidth-1:0]         right_data,
  input  logic signed [PRIORITY_WIDTH-1:0]      right_prio,
  output logic [spq_pkg::DataWidth-1:0]         data,
  output logic signed [PRIORITY_WIDTH-1:0]      prio,
  output logic                                  gt
);
  import spq_pkg::*;

  logic [DataWidth-1:0]              data_r;
  logic [DataWidth-1:0]              data_nxt;
  logic signed [PRIORITY_WIDTH-1:0]  prio_r;
  logic signed [PRIORITY_WIDTH-1:0]  prio_nxt;

  // An empty cell or one with a strictly larger priority moves aside for the new
  // entry; equal priorities stay in front, which keeps arrival order.
  assign gt = !occupied || (prio_r > new_prio);

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (ctl.enq && gt) begin
      if (left_gt) begin
        data_nxt = left_data;
        prio_nxt = left_prio;
      end else begin
        data_nxt = new_data;
        prio_nxt = new_prio;
      end
    end else if (ctl.deq) begin
      data_nxt = right_data;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule
